// ----- src/pica_pkg.sv -----
// ----------------------------------------------------------------------------
// pica_pkg
// Shared constants, request codes and controller/datapath interface types
// for the platform interrupt claim arbiter.
// ----------------------------------------------------------------------------
package pica_pkg;

    localparam int NUM_SOURCES   = 256;
    localparam int PRIORITY_BITS = 5;
    localparam int IDX_W         = $clog2(NUM_SOURCES);

    // Fixed field widths
    localparam int REQ_W = 3;
    localparam int ID_W  = 8;
    localparam int VAL_W = 5;
    localparam int THR_W = 5;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_SET_PRIORITY = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SET_ENABLE   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_RAISE        = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CLAIM        = 3'd3;
    localparam logic [REQ_W-1:0] REQ_COMPLETE     = 3'd4;

    // One entry of the source table
    typedef struct packed {
        logic [PRIORITY_BITS-1:0] prio;
        logic                     en;
        logic                     pend;
        logic                     insvc;
    } t_entry;

    // Controller to datapath commands
    typedef struct packed {
        logic             load;      // latch the request fields, clear scan results
        logic             rd_id;     // read the entry of the requested source
        logic             rd_scan;   // read entry scan_addr and evaluate it
        logic [IDX_W-1:0] scan_addr;
        logic             mod_wr;    // write back the modified requested entry
        logic             claim_wr;  // retire the winner of a claim
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_claim;
        logic do_rmw;
    } t_dp_sts;

endpackage

// ----- src/platform_interrupt_claim_arbiter.sv -----
// ----------------------------------------------------------------------------
// platform_interrupt_claim_arbiter
// Single-context platform-level interrupt controller with priority, enable,
// pending and in-service state per source, claim arbitration and threshold.
// ----------------------------------------------------------------------------
// A set priority, set enable, raise or complete on a source in range reads
// the entry of that source while the request is decoded and writes it back
// in the following cycle, before the scan. Every request ends with a scan
// over source entries 1 to NUM_SOURCES-1. The scan reads the source table
// memory one entry per cycle through its single read port. A claim writes
// the winner back after the scan. A finished result waits in the last state
// while the output register is full. One transaction is in flight at a time.
// The input is ready only when the block is idle, so a new transaction starts
// only after the last result has gone to the output register. A finished
// result is held in an output register until it is taken. Write the
// threshold through i_cfg_we / i_cfg_wdata while idle. Entries never written
// read as zero through per-entry valid bits cleared by reset, so there is no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module platform_interrupt_claim_arbiter
    import pica_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // request channel
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [REQ_W-1:0] i_req_type,
    input  logic [ID_W-1:0]  i_source_id,
    input  logic [VAL_W-1:0] i_write_value,
    // result channel
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [ID_W-1:0]  o_claimed_id,
    output logic             o_irq_line,
    // threshold register
    input  logic             i_cfg_we,
    input  logic [THR_W-1:0] i_cfg_wdata
);

    t_dp_cmd         cmd;
    t_dp_sts         sts;
    logic            done;
    logic            out_free;
    logic [ID_W-1:0] dp_claimed_id;
    logic            dp_irq_line;

    logic            r_out_valid;
    logic [ID_W-1:0] r_out_claimed_id;
    logic            r_out_irq_line;

    // The result register is free when empty or being drained this cycle
    assign out_free = !r_out_valid || i_out_ready;

    pica_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_done     (done),
        .o_cmd      (cmd)
    );

    pica_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_req_type    (i_req_type),
        .i_source_id   (i_source_id),
        .i_write_value (i_write_value),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_claimed_id  (dp_claimed_id),
        .o_irq_line    (dp_irq_line)
    );

    // Hold the result until the consumer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out_claimed_id <= dp_claimed_id;
            r_out_irq_line   <= dp_irq_line;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_claimed_id = r_out_claimed_id;
    assign o_irq_line   = r_out_irq_line;

    // Only a claim may grant a source
    a_grant_only_on_claim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done && !sts.is_claim |-> dp_claimed_id == '0)
        else $error("nonzero claimed id on a non-claim request");

    // One transaction at a time: no new acceptance right after one
    a_single_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted twice in a row");

    // A result is never produced over one still waiting
    a_no_result_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |-> !r_out_valid || i_out_ready)
        else $error("result register overwritten");

    // Table writes and scan reads never happen while idle
    a_no_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !cmd.mod_wr && !cmd.claim_wr && !cmd.rd_scan)
        else $error("table activity while idle");

endmodule

// ----- src/pica_dp.sv -----
// ----------------------------------------------------------------------------
// pica_dp
// Datapath: source table memory, threshold register, entry update logic and
// the running winner / eligible-count tracker of the scan.
// ----------------------------------------------------------------------------
module pica_dp
    import pica_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [THR_W-1:0] i_cfg_wdata,
    input  logic [REQ_W-1:0] i_req_type,
    input  logic [ID_W-1:0]  i_source_id,
    input  logic [VAL_W-1:0] i_write_value,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts,
    output logic [ID_W-1:0]  o_claimed_id,
    output logic             o_irq_line
);

    t_entry           mem [NUM_SOURCES];
    logic             r_vld [NUM_SOURCES];

    logic [THR_W-1:0] r_thresh;
    logic [REQ_W-1:0] r_req;
    logic [IDX_W-1:0] r_id_addr;
    logic [VAL_W-1:0] r_val;
    logic             r_valid_src;

    t_entry           r_rd_data;
    logic             r_rd_vld;
    logic [IDX_W-1:0] r_rd_addr;
    logic             r_rd_scan;

    logic [1:0]       r_cnt;
    logic [IDX_W-1:0] r_best_addr;
    logic [PRIORITY_BITS-1:0] r_best_pri;
    t_entry           r_best_entry;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    t_entry           rd_entry;
    t_entry           mod_entry;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;
    logic             elig;
    logic             take;

    // Threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= '0;
        end else if (i_cfg_we) begin
            r_thresh <= i_cfg_wdata;
        end
    end

    // Request latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req       <= i_req_type;
            r_id_addr   <= IDX_W'(i_source_id);
            r_val       <= i_write_value;
            r_valid_src <= (i_source_id != '0) && (32'(i_source_id) < NUM_SOURCES);
        end
    end

    always_comb begin
        o_sts.is_claim = (r_req == REQ_CLAIM);
        o_sts.do_rmw   = r_valid_src && (r_req inside {REQ_SET_PRIORITY, REQ_SET_ENABLE,
                                                       REQ_RAISE, REQ_COMPLETE});
    end

    // Table read port
    assign rd_en   = i_cmd.rd_id || i_cmd.rd_scan;
    assign rd_addr = i_cmd.rd_id ? r_id_addr : i_cmd.scan_addr;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
            r_rd_vld  <= r_vld[rd_addr];
            r_rd_addr <= rd_addr;
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Entry valid bits: an entry never written reads as all zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SOURCES; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    assign rd_entry = r_rd_vld ? r_rd_data : '0;

    // Update of the requested entry
    always_comb begin
        mod_entry = rd_entry;
        case (r_req)
            REQ_SET_PRIORITY: mod_entry.prio = PRIORITY_BITS'(r_val);
            REQ_SET_ENABLE:   mod_entry.en   = r_val[0];
            REQ_RAISE: begin
                if (!rd_entry.insvc) begin
                    mod_entry.pend = 1'b1;
                end
            end
            REQ_COMPLETE: begin
                if (rd_entry.en) begin
                    mod_entry.insvc = 1'b0;
                end
            end
            default: mod_entry = rd_entry;
        endcase
    end

    // Write port: requested entry update or claim retirement
    always_comb begin
        wr_en   = i_cmd.mod_wr || (i_cmd.claim_wr && (r_cnt != 2'd0));
        wr_addr = i_cmd.mod_wr ? r_id_addr : r_best_addr;
        wr_data = mod_entry;
        if (!i_cmd.mod_wr) begin
            wr_data       = r_best_entry;
            wr_data.pend  = 1'b0;
            wr_data.insvc = 1'b1;
        end
    end

    // Scan tracker: strict greater keeps the lowest ID on ties
    assign elig = rd_entry.en && rd_entry.pend
                  && (9'(rd_entry.prio) > 9'(r_thresh));
    assign take = elig && ((r_cnt == 2'd0) || (rd_entry.prio > r_best_pri));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_scan <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_rd_scan <= i_cmd.rd_scan;
            if (i_cmd.load) begin
                r_cnt <= '0;
            end else if (r_rd_scan && elig && (r_cnt != 2'd2)) begin
                r_cnt <= r_cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_scan && take) begin
            r_best_addr  <= r_rd_addr;
            r_best_pri   <= rd_entry.prio;
            r_best_entry <= rd_entry;
        end
    end

    // Results: after a claim the line stays up only if a second source qualified
    assign o_claimed_id = (o_sts.is_claim && (r_cnt != 2'd0)) ? ID_W'(r_best_addr) : '0;
    assign o_irq_line   = o_sts.is_claim ? (r_cnt == 2'd2) : (r_cnt != 2'd0);

endmodule

// ----- src/pica_ctrl.sv -----
// ----------------------------------------------------------------------------
// pica_ctrl
// Controller: sequences request load, read-modify-write of one entry, the
// table scan, claim retirement and result hand-off.
// ----------------------------------------------------------------------------
module pica_ctrl
    import pica_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_free,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output logic    o_done,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHK   = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_CWR   = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(NUM_SOURCES - 1);

    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= IDX_FIRST;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_idx           = r_idx;
        o_in_ready      = 1'b0;
        o_done          = 1'b0;
        o_cmd           = '0;
        o_cmd.scan_addr = r_idx;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_idx      = IDX_FIRST;
                    n_state    = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.do_rmw) begin
                    o_cmd.rd_id = 1'b1;
                    n_state     = S_MOD;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_MOD: begin
                o_cmd.mod_wr = 1'b1;
                n_state      = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.rd_scan = 1'b1;
                if (r_idx == IDX_LAST) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                n_state = i_sts.is_claim ? S_CWR : S_FIN;
            end
            S_CWR: begin
                o_cmd.claim_wr = 1'b1;
                n_state        = S_FIN;
            end
            S_FIN: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the platform interrupt claim arbiter. A queue-fed
// driver sends requests over the valid/ready input channel. A clocked monitor
// takes results from the output channel. An in-bench model of the source
// table (priority, enable, pending, in service, threshold) predicts the grant
// and the interrupt line for every accepted transaction. A directed sequence
// is followed by random phases, each under a threshold set for that phase.
// ----------------------------------------------------------------------------
module testbench;
    import pica_pkg::*;

    // Generous ceiling for the whole run, stalls included.
    localparam int CYCLE_LIMIT  = 1_000_000;
    // Cycles to watch for stray results after the last expected one.
    localparam int DRAIN_CYCLES = 300;
    localparam int HOT_SOURCES  = 12;

    // Request codes the block does not decode.
    localparam logic [REQ_W-1:0] REQ_UNKNOWN_FIRST = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNKNOWN_LAST  = 3'd7;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [ID_W-1:0]  id;
        logic [VAL_W-1:0] val;
    } t_req;

    typedef struct packed {
        logic [ID_W-1:0] claimed_id;
        logic            irq_line;
    } t_grant;

    logic             i_clk     = 1'b0;
    logic             i_rst_n   = 1'b0;
    logic             in_valid  = 1'b0;
    t_req             cur_req   = '0;
    logic             out_ready = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [THR_W-1:0] cfg_wdata = '0;

    wire              o_in_ready;
    wire              o_out_valid;
    wire [ID_W-1:0]   o_claimed_id;
    wire              o_irq_line;

    // Requests waiting to be driven, and grants waiting to be observed.
    t_req   req_q[$];
    t_grant grant_q[$];

    int errors    = 0;
    int cycles    = 0;
    int idle_pct  = 11;

    // Model of the source table and the threshold register.
    logic [PRIORITY_BITS-1:0] src_prio  [NUM_SOURCES];
    logic                     src_en    [NUM_SOURCES];
    logic                     src_pend  [NUM_SOURCES];
    logic                     src_insvc [NUM_SOURCES];
    logic [THR_W-1:0]         thr_model;

    platform_interrupt_claim_arbiter u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (cur_req.req),
        .i_source_id   (cur_req.id),
        .i_write_value (cur_req.val),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_claimed_id  (o_claimed_id),
        .o_irq_line    (o_irq_line),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Scan the table for the enabled pending source with the highest priority
    // above the threshold; the lowest ID wins a tie. Zero means nobody.
    function automatic logic [ID_W-1:0] best_source();
        logic [ID_W-1:0]          best;
        logic [PRIORITY_BITS-1:0] best_prio;
        best      = '0;
        best_prio = '0;
        for (int s = 1; s < NUM_SOURCES; s++) begin
            if (src_en[s] && src_pend[s] && src_prio[s] > thr_model &&
                (best == '0 || src_prio[s] > best_prio)) begin
                best      = ID_W'(s);
                best_prio = src_prio[s];
            end
        end
        return best;
    endfunction

    // Apply one request to the table model and return the grant it produces.
    function automatic t_grant apply_request(t_req r);
        t_grant g;
        logic   id_ok;
        g.claimed_id = '0;
        id_ok = (r.id != '0) && (int'(r.id) < NUM_SOURCES);
        if (r.req == REQ_CLAIM) begin
            g.claimed_id = best_source();
            if (g.claimed_id != '0) begin
                src_pend[g.claimed_id]  = 1'b0;
                src_insvc[g.claimed_id] = 1'b1;
            end
        end else if (id_ok) begin
            case (r.req)
                REQ_SET_PRIORITY: src_prio[r.id] = r.val[PRIORITY_BITS-1:0];
                REQ_SET_ENABLE:   src_en[r.id] = r.val[0];
                // the gateway holds a raise back while the source is served
                REQ_RAISE:        if (!src_insvc[r.id]) src_pend[r.id] = 1'b1;
                // only an enabled source can finish its service
                REQ_COMPLETE:     if (src_en[r.id]) src_insvc[r.id] = 1'b0;
                default: ;
            endcase
        end
        g.irq_line = (best_source() != '0);
        return g;
    endfunction

    // Driver: predict each accepted transaction, then present the next one
    // or drop valid. Valid is assigned once per edge, so a back-to-back item
    // keeps it high without a glitch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                grant_q.push_back(apply_request(cur_req));
            end
            if (!in_valid || o_in_ready) begin
                if (req_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    in_valid <= 1'b1;
                    cur_req  <= req_q.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each taken result against the oldest prediction,
    // then decide at random whether to stall the next cycle.
    always @(posedge i_clk) begin
        t_grant want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (grant_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result: expected none, %s %0d %s %0d",
                             $time, "got claimed_id", o_claimed_id,
                             "irq_line", o_irq_line);
                end else begin
                    want = grant_q.pop_front();
                    if (o_claimed_id !== want.claimed_id) begin
                        errors++;
                        $display("%0t: claimed_id mismatch: expected %0d, got %0d",
                                 $time, want.claimed_id, o_claimed_id);
                    end
                    if (o_irq_line !== want.irq_line) begin
                        errors++;
                        $display("%0t: irq_line mismatch: expected %0d, got %0d",
                                 $time, want.irq_line, o_irq_line);
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic push_req(input logic [REQ_W-1:0] r, input int id, input int v);
        t_req x;
        x.req = r;
        x.id  = ID_W'(id);
        x.val = VAL_W'(v);
        req_q.push_back(x);
    endtask

    // Hold until the driver has nothing left and every grant has come back.
    // Sample on the falling edge so the clocked blocks have settled.
    task automatic wait_idle();
        while (req_q.size() != 0 || in_valid || grant_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Write the threshold while the block is idle, then advance the model.
    task automatic write_threshold(input logic [THR_W-1:0] v);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        @(negedge i_clk);
        thr_model = v;
    endtask

    // One random phase: program a small hot set of sources, then mostly
    // raise / claim / complete traffic on that set, with some noise on the
    // full ID range, on source zero and with undecoded request codes.
    task automatic run_phase(input logic [THR_W-1:0] thr, input int n, input int pct);
        int sel;
        int id;
        int val;
        write_threshold(thr);
        idle_pct = pct;
        for (int s = 1; s <= HOT_SOURCES; s++) begin
            push_req(REQ_SET_PRIORITY, s, $urandom_range(1, 31));
            push_req(REQ_SET_ENABLE, s, ($urandom_range(15) << 1) | 1);
        end
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(99);
            id  = $urandom_range(99);
            id  = (id < 75) ? $urandom_range(1, HOT_SOURCES)
                : (id < 80) ? 0 : $urandom_range(255);
            val = $urandom_range(31);
            if (sel < 12) begin
                push_req(REQ_SET_PRIORITY, id, val);
            end else if (sel < 22) begin
                // keep most hot sources enabled so claims find work
                push_req(REQ_SET_ENABLE, id, ($urandom_range(3) != 0) ? (val | 1) : val);
            end else if (sel < 52) begin
                push_req(REQ_RAISE, id, val);
            end else if (sel < 75) begin
                push_req(REQ_CLAIM, id, val);
            end else if (sel < 95) begin
                push_req(REQ_COMPLETE, id, val);
            end else begin
                push_req(REQ_W'($urandom_range(REQ_UNKNOWN_FIRST, REQ_UNKNOWN_LAST)),
                         id, val);
            end
        end
        wait_idle();
    endtask

    initial begin
        for (int s = 0; s < NUM_SOURCES; s++) begin
            src_prio[s]  = '0;
            src_en[s]    = 1'b0;
            src_pend[s]  = 1'b0;
            src_insvc[s] = 1'b0;
        end
        thr_model = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, threshold at its reset value.
        // Source zero ignores everything but a claim.
        push_req(REQ_SET_PRIORITY, 0, 31);
        push_req(REQ_SET_ENABLE, 0, 1);
        push_req(REQ_RAISE, 0, 0);
        push_req(REQ_COMPLETE, 0, 0);
        // Two sources tied at top priority at both ends of the ID range.
        push_req(REQ_SET_PRIORITY, 255, 31);
        push_req(REQ_SET_PRIORITY, 1, 31);
        push_req(REQ_SET_ENABLE, 255, 31);
        push_req(REQ_SET_ENABLE, 1, 1);
        push_req(REQ_RAISE, 255, 0);
        push_req(REQ_RAISE, 1, 0);
        push_req(REQ_RAISE, 1, 0);          // raise while already pending
        push_req(REQ_CLAIM, 0, 0);          // tie goes to the lowest ID
        push_req(REQ_RAISE, 1, 0);          // raise while in service
        push_req(REQ_CLAIM, 255, 31);       // ID and value are ignored on a claim
        push_req(REQ_CLAIM, 0, 0);          // nothing left to grant
        push_req(REQ_SET_ENABLE, 1, 30);    // enable bit clear, upper bits set
        push_req(REQ_COMPLETE, 1, 0);       // disabled: stays in service
        push_req(REQ_RAISE, 1, 0);
        push_req(REQ_SET_ENABLE, 1, 1);
        push_req(REQ_COMPLETE, 1, 0);
        push_req(REQ_COMPLETE, 1, 0);       // no longer in service
        // Priority zero can never be claimed.
        push_req(REQ_SET_PRIORITY, 2, 0);
        push_req(REQ_SET_ENABLE, 2, 1);
        push_req(REQ_RAISE, 2, 0);
        push_req(REQ_CLAIM, 0, 0);
        push_req(REQ_UNKNOWN_LAST, 255, 31);
        push_req(REQ_UNKNOWN_FIRST, 2, 0);
        wait_idle();

        // Random phases across thresholds, extremes included; the third one
        // runs with no idling on either side.
        run_phase(5'd4, 110, 11);
        run_phase(5'd31, 40, 11);
        run_phase(5'd0, 130, 0);
        run_phase(THR_W'($urandom_range(1, 30)), 120, 11);
        run_phase(5'd1, 110, 11);

        // Watch for stray results before closing.
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (grant_q.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, grant_q.size());
        end
        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
